### src/quaternion_alu_core_macros.svh
// Assertion macros shared by the quaternion ALU top level.
// No dependencies.
`ifndef QUATERNION_ALU_CORE_MACROS_SVH
`define QUATERNION_ALU_CORE_MACROS_SVH

// assert that a implies b in the next cycle
`define QA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// assert that a implies b in the same cycle
`define QA_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

### src/qalu_pkg.sv
// Package for the quaternion ALU: operation codes, widths, saturation helper.
// No dependencies.
package qalu_pkg;
    localparam int W = 32;
    localparam int PW = 64;   // full product width
    localparam int SW = 52;   // sum width for accumulating floored products

    typedef enum logic [1:0] {
        FUNC_MUL = 2'd0,
        FUNC_ROT = 2'd1,
        FUNC_CONJ = 2'd2,
        FUNC_NEG = 2'd3
    } func_t;

    typedef logic signed [W-1:0] q_t;
    typedef logic signed [SW-1:0] acc_t;

    // floored product (arithmetic shift floors)
    function automatic acc_t fmul(input q_t p, input q_t q, input int unsigned sh);
        logic signed [PW-1:0] pr;
        begin
            pr = PW'(p) * PW'(q);
            pr = pr >>> sh;
            fmul = pr[SW-1:0];
        end
    endfunction

    function automatic q_t sat(input acc_t v);
        begin
            if (v > acc_t'(32'sh7fffffff)) sat = 32'sh7fffffff;
            else if (v < -acc_t'(33'sh080000000)) sat = 32'sh80000000;
            else sat = v[W-1:0];
        end
    endfunction

    function automatic logic is_sat(input acc_t v);
        begin
            is_sat = (v > acc_t'(32'sh7fffffff)) || (v < -acc_t'(33'sh080000000));
        end
    endfunction
endpackage

### src/quaternion_alu_core.sv
// Quaternion ALU top level: four-stage pipeline (products, cross sums,
// second cross, output). Uses qalu_pkg, qalu_stage and the macro header.
//
// Usage:
//   Input channel: valid/stall with func and quaternions a, b. A word is
//   taken on a rising edge with valid high and stall low.
//   Output channel: out_valid/out_stall with r_x..r_w and overflow.
//   Throughput: one word per cycle while out_stall is low. The rotate path
//   needs two chained cross products, each a rank of 32x32 multipliers
//   behind its own register, which sets the depth.
//   Stages:
//     1: all first-level products (multiply and a x v), floored.
//     2: sums, saturation of c = a x v; conjugate/negate results.
//     3: products a x c and 2*a_w*c, floored.
//     4: final sums, saturation, overflow, output register.
//   Stall: a full stage holds if the next holds, the last if out_stall is
//   high; input stall rises only when all hold, so nothing is lost. Bubbles
//   are squeezed out: a stage advances whenever its successor can accept.
//   Reset clears all valid bits; payload registers are not reset.
`include "quaternion_alu_core_macros.svh"
module quaternion_alu_core
    import qalu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] r_w,
    output logic               overflow
);
    // stage 1 payload
    typedef struct packed {
        func_t func;
        q_t ax, ay, az, aw, bx, by, bz;
        acc_t p0, p1, p2, p3;   // multiply terms
        acc_t m0, m1, m2, m3;   // second half of multiply terms
        acc_t n0, n1, n2, n3;
        acc_t k0, k1, k2, k3;
        acc_t c0a, c0b, c1a, c1b, c2a, c2b; // a x v terms
    } s1_t;

    typedef struct packed {
        func_t func;
        q_t ax, ay, az, aw, bx, by, bz;
        q_t c0, c1, c2;
        acc_t mw, mx, my, mz;
        logic ovf;
    } s2_t;

    typedef struct packed {
        func_t func;
        q_t bx, by, bz;
        acc_t mw, mx, my, mz;
        acc_t d0a, d0b, d1a, d1b, d2a, d2b;
        acc_t e0, e1, e2;
        logic ovf;
    } s3_t;

    typedef struct packed {
        q_t rx, ry, rz, rw;
        logic ovf;
    } s4_t;

    s1_t s1_next, s1_q;
    s2_t s2_next, s2_q;
    s3_t s3_next, s3_q;
    s4_t s4_next, s4_q;
    logic v1, v2, v3, v4;
    logic h1, h2, h3, h4;
    acc_t dx, dy, dz, fx, fy, fz;

    // hold chain: a stage holds when it is full and its successor holds
    assign h4 = v4 && out_stall;
    assign h3 = v3 && h4;
    assign h2 = v2 && h3;
    assign h1 = v1 && h2;
    assign stall = h1;

    always_comb
    begin
        s1_next.func = func_t'(func);
        s1_next.ax = a_x; s1_next.ay = a_y; s1_next.az = a_z; s1_next.aw = a_w;
        s1_next.bx = b_x; s1_next.by = b_y; s1_next.bz = b_z;
        s1_next.p0 = fmul(a_w, b_w, 16); s1_next.p1 = fmul(a_x, b_x, 16);
        s1_next.p2 = fmul(a_y, b_y, 16); s1_next.p3 = fmul(a_z, b_z, 16);
        s1_next.m0 = fmul(a_w, b_x, 16); s1_next.m1 = fmul(b_w, a_x, 16);
        s1_next.m2 = fmul(b_y, a_z, 16); s1_next.m3 = fmul(b_z, a_y, 16);
        s1_next.n0 = fmul(a_w, b_y, 16); s1_next.n1 = fmul(b_w, a_y, 16);
        s1_next.n2 = fmul(b_z, a_x, 16); s1_next.n3 = fmul(b_x, a_z, 16);
        s1_next.k0 = fmul(a_w, b_z, 16); s1_next.k1 = fmul(b_w, a_z, 16);
        s1_next.k2 = fmul(b_x, a_y, 16); s1_next.k3 = fmul(b_y, a_x, 16);
        s1_next.c0a = fmul(a_y, b_z, 16); s1_next.c0b = fmul(a_z, b_y, 16);
        s1_next.c1a = fmul(a_z, b_x, 16); s1_next.c1b = fmul(a_x, b_z, 16);
        s1_next.c2a = fmul(a_x, b_y, 16); s1_next.c2b = fmul(a_y, b_x, 16);
    end

    qalu_stage #(.PW_BITS($bits(s1_t))) u_s1 (
        .clk(clk), .rst_n(rst_n), .in_valid(valid), .in_data(s1_next),
        .hold(h1), .valid(v1), .data(s1_q)
    );

    always_comb
    begin
        acc_t c0, c1, c2;
        c0 = s1_q.c0a - s1_q.c0b;
        c1 = s1_q.c1a - s1_q.c1b;
        c2 = s1_q.c2a - s1_q.c2b;
        s2_next.func = s1_q.func;
        s2_next.ax = s1_q.ax; s2_next.ay = s1_q.ay; s2_next.az = s1_q.az;
        s2_next.aw = s1_q.aw;
        s2_next.bx = s1_q.bx; s2_next.by = s1_q.by; s2_next.bz = s1_q.bz;
        s2_next.c0 = sat(c0); s2_next.c1 = sat(c1); s2_next.c2 = sat(c2);
        s2_next.ovf = is_sat(c0) || is_sat(c1) || is_sat(c2);
        s2_next.mw = s1_q.p0 - s1_q.p1 - s1_q.p2 - s1_q.p3;
        s2_next.mx = s1_q.m0 + s1_q.m1 + s1_q.m2 - s1_q.m3;
        s2_next.my = s1_q.n0 + s1_q.n1 + s1_q.n2 - s1_q.n3;
        s2_next.mz = s1_q.k0 + s1_q.k1 + s1_q.k2 - s1_q.k3;
        case (s1_q.func)
            FUNC_CONJ, FUNC_NEG:
            begin
                s2_next.mx = -acc_t'(s1_q.ax);
                s2_next.my = -acc_t'(s1_q.ay);
                s2_next.mz = -acc_t'(s1_q.az);
                s2_next.mw = (s1_q.func == FUNC_CONJ) ? acc_t'(s1_q.aw)
                                                      : -acc_t'(s1_q.aw);
            end
            default:
            begin
            end
        endcase
    end

    qalu_stage #(.PW_BITS($bits(s2_t))) u_s2 (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_data(s2_next),
        .hold(h2), .valid(v2), .data(s2_q)
    );

    always_comb
    begin
        s3_next.func = s2_q.func;
        s3_next.bx = s2_q.bx; s3_next.by = s2_q.by; s3_next.bz = s2_q.bz;
        s3_next.mw = s2_q.mw; s3_next.mx = s2_q.mx;
        s3_next.my = s2_q.my; s3_next.mz = s2_q.mz;
        s3_next.ovf = (s2_q.func == FUNC_ROT) && s2_q.ovf;
        s3_next.d0a = fmul(s2_q.ay, s2_q.c2, 16); s3_next.d0b = fmul(s2_q.az, s2_q.c1, 16);
        s3_next.d1a = fmul(s2_q.az, s2_q.c0, 16); s3_next.d1b = fmul(s2_q.ax, s2_q.c2, 16);
        s3_next.d2a = fmul(s2_q.ax, s2_q.c1, 16); s3_next.d2b = fmul(s2_q.ay, s2_q.c0, 16);
        s3_next.e0 = fmul(s2_q.aw, s2_q.c0, 15);
        s3_next.e1 = fmul(s2_q.aw, s2_q.c1, 15);
        s3_next.e2 = fmul(s2_q.aw, s2_q.c2, 15);
    end

    qalu_stage #(.PW_BITS($bits(s3_t))) u_s3 (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .in_data(s3_next),
        .hold(h3), .valid(v3), .data(s3_q)
    );

    always_comb
    begin
        logic o;
        dx = s3_q.d0a - s3_q.d0b;
        dy = s3_q.d1a - s3_q.d1b;
        dz = s3_q.d2a - s3_q.d2b;
        o = s3_q.ovf;
        if (s3_q.func == FUNC_ROT)
        begin
            o = o || is_sat(dx) || is_sat(dy) || is_sat(dz);
            fx = acc_t'(s3_q.bx) + s3_q.e0 + (acc_t'(sat(dx)) <<< 1);
            fy = acc_t'(s3_q.by) + s3_q.e1 + (acc_t'(sat(dy)) <<< 1);
            fz = acc_t'(s3_q.bz) + s3_q.e2 + (acc_t'(sat(dz)) <<< 1);
            s4_next.rw = '0;
        end
        else
        begin
            fx = s3_q.mx; fy = s3_q.my; fz = s3_q.mz;
            o = o || is_sat(s3_q.mw);
            s4_next.rw = sat(s3_q.mw);
        end
        s4_next.rx = sat(fx); s4_next.ry = sat(fy); s4_next.rz = sat(fz);
        s4_next.ovf = o || is_sat(fx) || is_sat(fy) || is_sat(fz);
    end

    qalu_stage #(.PW_BITS($bits(s4_t))) u_s4 (
        .clk(clk), .rst_n(rst_n), .in_valid(v3), .in_data(s4_next),
        .hold(h4), .valid(v4), .data(s4_q)
    );

    assign out_valid = v4;
    assign r_x = s4_q.rx;
    assign r_y = s4_q.ry;
    assign r_z = s4_q.rz;
    assign r_w = s4_q.rw;
    assign overflow = s4_q.ovf;

    `QA_ASSERT_NOW(a_stall_full, clk, rst_n, stall, v1 && v2 && v3 && v4)
    `QA_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(r_x) && $stable(overflow))
    `QA_ASSERT_NEXT(a_flow, clk, rst_n, valid && !stall, v1)
endmodule

### src/qalu_stage.sv
// One pipeline register stage with stall, carrying a payload of width PW_BITS.
// Depends on nothing.
module qalu_stage #(
    parameter int PW_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PW_BITS-1:0] in_data,
    input  logic               hold,
    output logic               valid,
    output logic [PW_BITS-1:0] data
);
    logic valid_reg;
    logic [PW_BITS-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign valid = valid_reg;
    assign data = data_reg;
endmodule

### tb/sv/quaternion_alu_core_test.sv
// Self-checking testbench for quaternion_alu_core: multiply, rotate, conjugate, negate.
// Depends on qalu_pkg and the quaternion_alu_core RTL.
module quaternion_alu_core_test;
    import qalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw;
    } qword_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, rw;
        logic               ovf;
    } qres_t;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               stall;
    logic [1:0]         func;
    logic signed [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] r_x, r_y, r_z, r_w;
    logic               overflow;

    qres_t  expected_q[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     quiet_sender;   // disables sender gaps
    bit     quiet_sink;     // disables receiver stalls

    quaternion_alu_core dut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall), .func(func),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floored Q16.16 product, shift s
    function automatic longint fprod(longint p, longint q, int s);
        longint x;
        x = p * q;
        return x >>> s;
    endfunction

    function automatic longint clamp32(longint v, ref bit ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic qres_t quat_result(qword_t w);
        longint a[4], b[4], r[4], c[3], d[3];
        bit     ovf;
        qres_t  res;
        ovf = 1'b0;
        a[0] = w.ax; a[1] = w.ay; a[2] = w.az; a[3] = w.aw;
        b[0] = w.bx; b[1] = w.by; b[2] = w.bz; b[3] = w.bw;
        case (func_t'(w.func))
            FUNC_MUL:
            begin
                r[3] = fprod(a[3], b[3], 16) - fprod(a[0], b[0], 16)
                     - fprod(a[1], b[1], 16) - fprod(a[2], b[2], 16);
                r[0] = fprod(a[3], b[0], 16) + fprod(b[3], a[0], 16)
                     + fprod(b[1], a[2], 16) - fprod(b[2], a[1], 16);
                r[1] = fprod(a[3], b[1], 16) + fprod(b[3], a[1], 16)
                     + fprod(b[2], a[0], 16) - fprod(b[0], a[2], 16);
                r[2] = fprod(a[3], b[2], 16) + fprod(b[3], a[2], 16)
                     + fprod(b[0], a[1], 16) - fprod(b[1], a[0], 16);
            end
            FUNC_ROT:
            begin
                // c = a x v, d = a x c, both saturated
                c[0] = clamp32(fprod(a[1], b[2], 16) - fprod(a[2], b[1], 16), ovf);
                c[1] = clamp32(fprod(a[2], b[0], 16) - fprod(a[0], b[2], 16), ovf);
                c[2] = clamp32(fprod(a[0], b[1], 16) - fprod(a[1], b[0], 16), ovf);
                d[0] = clamp32(fprod(a[1], c[2], 16) - fprod(a[2], c[1], 16), ovf);
                d[1] = clamp32(fprod(a[2], c[0], 16) - fprod(a[0], c[2], 16), ovf);
                d[2] = clamp32(fprod(a[0], c[1], 16) - fprod(a[1], c[0], 16), ovf);
                for (int i = 0; i < 3; i++)
                    r[i] = b[i] + fprod(a[3], c[i], 15) + 2 * d[i];
                r[3] = 0;
            end
            default:
            begin
                r[0] = -a[0];
                r[1] = -a[1];
                r[2] = -a[2];
                r[3] = (func_t'(w.func) == FUNC_CONJ) ? a[3] : -a[3];
            end
        endcase
        res.rx = 32'(clamp32(r[0], ovf));
        res.ry = 32'(clamp32(r[1], ovf));
        res.rz = 32'(clamp32(r[2], ovf));
        res.rw = 32'(clamp32(r[3], ovf));
        res.ovf = ovf;
        return res;
    endfunction

    // random idle draw, about 6 in 100
    function automatic bit idle_draw();
        return $urandom_range(99) < 6;
    endfunction

    // drive one word at the current edge, hold until accepted;
    // returns at the accepting edge so the next word can follow with no gap
    task automatic send_word(qword_t w);
        while (!quiet_sender && idle_draw())
        begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid <= 1'b1;
        func <= w.func;
        a_x <= w.ax; a_y <= w.ay; a_z <= w.az; a_w <= w.aw;
        b_x <= w.bx; b_y <= w.by; b_z <= w.bz; b_w <= w.bw;
        expected_q.push_back(quat_result(w));
        do @(posedge clk); while (stall);
    endtask

    // lower valid after the last accepted word
    task automatic end_burst();
        valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00010000;
            3: return -32'sh00010000;
            4: return $signed(32'($urandom_range(131071)) - 32'sd65536);
            5: return $signed(32'($urandom_range(16777215)) - 32'sd8388608);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic qword_t rand_word();
        qword_t w;
        w.func = 2'($urandom_range(3));
        w.ax = rand_q(); w.ay = rand_q(); w.az = rand_q(); w.aw = rand_q();
        w.bx = rand_q(); w.by = rand_q(); w.bz = rand_q(); w.bw = rand_q();
        return w;
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word r=%h %h %h %h ovf=%b", $time,
                             r_x, r_y, r_z, r_w, overflow);
                    errors++;
                end
                else
                begin
                    qres_t e;
                    e = expected_q.pop_front();
                    if (r_x !== e.rx)
                    begin
                        $display("%0t: r_x exp %h got %h", $time, e.rx, r_x);
                        errors++;
                    end
                    if (r_y !== e.ry)
                    begin
                        $display("%0t: r_y exp %h got %h", $time, e.ry, r_y);
                        errors++;
                    end
                    if (r_z !== e.rz)
                    begin
                        $display("%0t: r_z exp %h got %h", $time, e.rz, r_z);
                        errors++;
                    end
                    if (r_w !== e.rw)
                    begin
                        $display("%0t: r_w exp %h got %h", $time, e.rw, r_w);
                        errors++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $display("%0t: overflow exp %b got %b", $time, e.ovf, overflow);
                        errors++;
                    end
                end
            end
            out_stall <= quiet_sink ? 1'b0 : idle_draw();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with nothing accepted on either side
    always @(posedge clk)
    begin
        if ((valid && !stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("quaternion_alu_core_test NOT OK");
            $finish;
        end
    end

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        qword_t w;
        logic signed [31:0] v[4];
        v[0] = 32'sh7fffffff; v[1] = 32'sh80000000; v[2] = '0; v[3] = 32'sh00010000;
        for (int f = 0; f < 4; f++)
            for (int k = 0; k < 4; k++)
            begin
                w.func = 2'(f);
                w.ax = v[k]; w.ay = v[(k + 1) % 4]; w.az = v[(k + 2) % 4];
                w.aw = v[(k + 3) % 4];
                w.bx = v[(k + 2) % 4]; w.by = v[k]; w.bz = v[(k + 3) % 4];
                w.bw = v[(k + 1) % 4];
                send_word(w);
            end
        // unit rotation about z applied to x axis
        w = '0;
        w.func = FUNC_ROT; w.az = 32'sd46341; w.aw = 32'sd46341; w.bx = 32'sh00010000;
        w.bw = 32'sh80000000;
        send_word(w);
        // negate of most negative everywhere
        w.func = FUNC_NEG;
        w.ax = 32'sh80000000; w.ay = 32'sh80000000; w.az = 32'sh80000000;
        w.aw = 32'sh80000000;
        send_word(w);
        w.func = FUNC_CONJ;
        send_word(w);
        end_burst();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(rand_word());
        end_burst();
    endtask

    // sender waits for the pipeline to empty between words
    task automatic test_drained();
        for (int i = 0; i < 20; i++)
        begin
            send_word(rand_word());
            end_burst();
            drain();
        end
    endtask

    // stretch with no idling on either side
    task automatic test_streaming();
        quiet_sender = 1'b1;
        quiet_sink = 1'b1;
        test_random(300);
        drain();
        quiet_sender = 1'b0;
        quiet_sink = 1'b0;
    endtask

    initial
    begin
        quiet_sender = 1'b0;
        quiet_sink = 1'b0;
        rst_n = 1'b0;
        valid = 1'b0;
        func = '0;
        a_x = '0; a_y = '0; a_z = '0; a_w = '0;
        b_x = '0; b_y = '0; b_z = '0; b_w = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_drained();
        test_random(700);
        test_streaming();
        test_random(700);
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("quaternion_alu_core_test OK");
        else
            $display("quaternion_alu_core_test NOT OK");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/qalu_pkg.sv
src/qalu_stage.sv
src/quaternion_alu_core.sv
tb/sv/quaternion_alu_core_test.sv
